/* hdl/eft_pkg.sv */
`default_nettype none

package eft_pkg;

	// Table geometry.
	localparam int MAX_ENTRIES = 32;
	localparam int SLOT_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	// Field widths fixed by the interface.
	localparam int ADDR_W = 32;
	localparam int ID_W = 16;
	localparam int TIME_W = 32;
	localparam int TMO_W = 16;
	localparam int OUT_SLOT_W = 5;
	localparam int IN_SLOT_W = 5;

	// Idle timeout after reset, in seconds.
	localparam logic [TMO_W-1:0] TIMEOUT_RESET = TMO_W'(10);

	// Request codes.
	typedef enum logic [1:0] {
		REQ_LOOKUP = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_AGE    = 2'd2,
		REQ_REPLY  = 2'd3
	} req_t;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_MATCH   = 3'd0,
		ST_CREATED = 3'd1,
		ST_FULL    = 3'd2,
		ST_REMOVED = 3'd3,
		ST_NONE    = 3'd4
	} status_t;

	// One table entry as held in the entry memory.
	typedef struct packed {
		logic [ADDR_W-1:0] src;
		logic [ADDR_W-1:0] dst;
		logic [ID_W-1:0]   id;
		logic [ADDR_W-1:0] redir;
		logic [TIME_W-1:0] last;
	} entry_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_SLOT = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

endpackage

`default_nettype wire

/* hdl/echo_flow_table.sv */
// Lookup: the key memory is scanned one entry per cycle through its single read port,
// stopping at the first hit; a miss runs to the last slot. Remove, age and reply read the
// slot's entry first, skipped when the slot is not live. A new item is taken only once the
// result has passed the pending register into the output register.
// Reset (arst_n low) clears all valid bits, the live count and the sequencer and loads
// the idle timeout with 10; the entry memory itself is not cleared.
`default_nettype none

module echo_flow_table (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// Request channel.
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [1:0]                         req_type,
	input  wire logic [eft_pkg::ADDR_W-1:0]         source_addr,
	input  wire logic [eft_pkg::ADDR_W-1:0]         dst_addr,
	input  wire logic [eft_pkg::ID_W-1:0]           echo_id,
	input  wire logic [eft_pkg::ADDR_W-1:0]         redirect_addr,
	input  wire logic [eft_pkg::TIME_W-1:0]         now_seconds,
	input  wire logic [eft_pkg::IN_SLOT_W-1:0]      slot_index,
	input  wire logic [eft_pkg::ADDR_W-1:0]         peer_addr,
	// Result channel.
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [2:0]                              status,
	output logic [eft_pkg::OUT_SLOT_W-1:0]          slot_out,
	output logic [eft_pkg::ADDR_W-1:0]              forward_addr,
	output logic [eft_pkg::ADDR_W-1:0]              guest_addr,
	output logic [eft_pkg::ID_W-1:0]                id_out,
	// Timeout register write channel.
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [eft_pkg::TMO_W-1:0]          cfg_data
);
	import eft_pkg::*;

	state_t                  state_q, state_d;

	// Captured request.
	req_t                    req_q;
	logic [ADDR_W-1:0]       src_q, dst_q, redir_q, peer_q;
	logic [ID_W-1:0]         id_q;
	logic [TIME_W-1:0]       now_q;

	// Table state held in flops.
	logic [MAX_ENTRIES-1:0]  valid_q;
	logic [CNT_W-1:0]        live_q;
	logic [TMO_W-1:0]        timeout_q;

	// Scan control and compare stage.
	logic [SLOT_W-1:0]       scan_q;
	logic                    issue_q;
	logic                    cmp_v_s1;
	logic [SLOT_W-1:0]       cmp_slot_s1;
	logic                    cmp_last_s1;
	logic                    free_found_q;
	logic [SLOT_W-1:0]       free_slot_q;
	logic [SLOT_W-1:0]       slot_q;

	// Entry memory.
	entry_t                  entry_mem [MAX_ENTRIES];
	entry_t                  mem_rd_q;
	logic                    mem_re, mem_we;
	logic [SLOT_W-1:0]       mem_ra, mem_wa;
	entry_t                  mem_wd;

	// Pending result and output register.
	logic                    res_en;
	status_t                 res_st;
	logic [OUT_SLOT_W-1:0]   res_slot;
	logic [ADDR_W-1:0]       res_fwd, res_guest;
	logic [ID_W-1:0]         res_id;
	status_t                 res_st_q;
	logic [OUT_SLOT_W-1:0]   res_slot_q;
	logic [ADDR_W-1:0]       res_fwd_q, res_guest_q;
	logic [ID_W-1:0]         res_id_q;
	logic                    out_load;
	logic                    out_valid_q;
	status_t                 out_st_q;
	logic [OUT_SLOT_W-1:0]   out_slot_q;
	logic [ADDR_W-1:0]       out_fwd_q, out_guest_q;
	logic [ID_W-1:0]         out_id_q;

	// Valid bit updates.
	logic                    set_en, clr_en;
	logic [SLOT_W-1:0]       upd_slot;

	logic                    slot_ok_in;
	logic                    hit;
	logic [TIME_W-1:0]       idle_time;
	logic                    stale;

	// Handshakes.
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	// A slot request is only worth a memory read when the slot is live.
	assign slot_ok_in = (int'(slot_index) < MAX_ENTRIES) && valid_q[SLOT_W'(slot_index)];

	// Key compare on the entry read back in the previous cycle.
	assign hit = cmp_v_s1 && valid_q[cmp_slot_s1] && (mem_rd_q.src == src_q) &&
		(mem_rd_q.dst == dst_q) && (mem_rd_q.id == id_q);

	// Idle time wraps modulo 2^32.
	assign idle_time = now_q - mem_rd_q.last;
	assign stale     = idle_time > TIME_W'(timeout_q);

	// Sequencer: memory accesses, valid bit updates and the pending result.
	always_comb begin
		state_d   = state_q;
		mem_re    = 1'b0;
		mem_ra    = scan_q;
		mem_we    = 1'b0;
		mem_wa    = cmp_slot_s1;
		mem_wd    = mem_rd_q;
		set_en    = 1'b0;
		clr_en    = 1'b0;
		upd_slot  = slot_q;
		res_en    = 1'b0;
		res_st    = ST_NONE;
		res_slot  = '0;
		res_fwd   = '0;
		res_guest = '0;
		res_id    = '0;
		out_load  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (req_t'(req_type) == REQ_LOOKUP) begin
						state_d = S_SCAN;
					end else if (slot_ok_in) begin
						mem_re  = 1'b1;
						mem_ra  = SLOT_W'(slot_index);
						state_d = S_SLOT;
					end else begin
						res_en  = 1'b1;
						state_d = S_OUT;
					end
				end
			end
			S_SCAN: begin
				if (issue_q) begin
					mem_re = 1'b1;
					mem_ra = scan_q;
				end
				if (hit) begin
					// Refresh the matched entry and forward.
					mem_we      = 1'b1;
					mem_wa      = cmp_slot_s1;
					mem_wd      = mem_rd_q;
					mem_wd.last = now_q;
					res_en      = 1'b1;
					res_st      = ST_MATCH;
					res_slot    = OUT_SLOT_W'(cmp_slot_s1);
					res_fwd     = (mem_rd_q.redir != '0) ? mem_rd_q.redir : mem_rd_q.dst;
					state_d     = S_OUT;
				end else if (cmp_v_s1 && cmp_last_s1) begin
					// Miss: claim the lowest free slot unless the table is full.
					res_en = 1'b1;
					if ((live_q >= CNT_W'(MAX_ENTRIES)) || !free_found_q) begin
						res_st = ST_FULL;
					end else begin
						mem_we   = 1'b1;
						mem_wa   = free_slot_q;
						mem_wd   = '{src: src_q, dst: dst_q, id: id_q, redir: redir_q,
							last: now_q};
						set_en   = 1'b1;
						upd_slot = free_slot_q;
						res_st   = ST_CREATED;
						res_slot = OUT_SLOT_W'(free_slot_q);
						res_fwd  = (redir_q != '0) ? redir_q : dst_q;
					end
					state_d = S_OUT;
				end
			end
			S_SLOT: begin
				res_en = 1'b1;
				case (req_q)
					REQ_REMOVE: begin
						clr_en   = 1'b1;
						res_st   = ST_REMOVED;
						res_slot = OUT_SLOT_W'(slot_q);
					end
					REQ_AGE: begin
						if (stale) begin
							clr_en   = 1'b1;
							res_st   = ST_REMOVED;
							res_slot = OUT_SLOT_W'(slot_q);
						end
					end
					REQ_REPLY: begin
						mem_we      = 1'b1;
						mem_wa      = slot_q;
						mem_wd      = mem_rd_q;
						mem_wd.last = now_q;
						res_st      = ST_MATCH;
						res_slot    = OUT_SLOT_W'(slot_q);
						res_fwd     = (mem_rd_q.redir != '0) ? mem_rd_q.dst : peer_q;
						res_guest   = mem_rd_q.src;
						res_id      = mem_rd_q.id;
					end
					default: begin
					end
				endcase
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Entry memory with one write and one registered read port. Writes only happen when an
	// item's result is produced, before the handover state, so a read of the next item never overlaps them.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			entry_mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			mem_rd_q <= entry_mem[mem_ra];
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= '0;
			live_q       <= '0;
			timeout_q    <= TIMEOUT_RESET;
			scan_q       <= '0;
			issue_q      <= 1'b0;
			cmp_v_s1     <= 1'b0;
			free_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_valid && cfg_ready) begin
				timeout_q <= cfg_data;
			end

			// Valid bits and live count.
			if (set_en) begin
				valid_q[upd_slot] <= 1'b1;
				live_q            <= live_q + 1'b1;
			end else if (clr_en) begin
				valid_q[upd_slot] <= 1'b0;
				live_q            <= live_q - 1'b1;
			end

			// Scan address and lowest free slot.
			if (state_q == S_IDLE && in_valid && req_t'(req_type) == REQ_LOOKUP) begin
				scan_q       <= '0;
				issue_q      <= 1'b1;
				free_found_q <= 1'b0;
				cmp_v_s1     <= 1'b0;
			end else if (state_q == S_SCAN && state_d == S_SCAN) begin
				cmp_v_s1 <= issue_q;
				if (issue_q) begin
					scan_q  <= SLOT_W'(scan_q + 1'b1);
					issue_q <= (scan_q != SLOT_W'(MAX_ENTRIES - 1));
					if (!valid_q[scan_q] && !free_found_q) begin
						free_found_q <= 1'b1;
					end
				end
			end else begin
				issue_q  <= 1'b0;
				cmp_v_s1 <= 1'b0;
			end

			// Output register.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			req_q   <= req_t'(req_type);
			src_q   <= source_addr;
			dst_q   <= dst_addr;
			id_q    <= echo_id;
			redir_q <= redirect_addr;
			now_q   <= now_seconds;
			peer_q  <= peer_addr;
			slot_q  <= SLOT_W'(slot_index);
		end
		if (state_q == S_SCAN && issue_q) begin
			cmp_slot_s1 <= scan_q;
			cmp_last_s1 <= (scan_q == SLOT_W'(MAX_ENTRIES - 1));
			if (!valid_q[scan_q] && !free_found_q) begin
				free_slot_q <= scan_q;
			end
		end
		if (res_en) begin
			res_st_q    <= res_st;
			res_slot_q  <= res_slot;
			res_fwd_q   <= res_fwd;
			res_guest_q <= res_guest;
			res_id_q    <= res_id;
		end
		if (out_load) begin
			out_st_q    <= res_st_q;
			out_slot_q  <= res_slot_q;
			out_fwd_q   <= res_fwd_q;
			out_guest_q <= res_guest_q;
			out_id_q    <= res_id_q;
		end
	end

	// Result ports.
	assign out_valid    = out_valid_q;
	assign status       = out_st_q;
	assign slot_out     = out_slot_q;
	assign forward_addr = out_fwd_q;
	assign guest_addr   = out_guest_q;
	assign id_out       = out_id_q;

	// The live count always agrees with the valid bits.
	a_live_count: assert property (@(posedge clk) disable iff (!arst_n)
		int'(live_q) == $countones(valid_q))
		else $error("live count differs from the number of valid entries");

	// A new result only appears after the sequencer has handed it over.
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result appeared without passing the handover state");

	// A scan that writes without a hit is claiming a free slot.
	a_claim_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && mem_we && !hit) |-> !valid_q[mem_wa])
		else $error("lookup miss overwrote a live entry");

	// The sequencer never returns to idle from a scan or slot access without producing a result.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_SLOT) |=> (state_q != S_IDLE || $past(res_en)))
		else $error("sequencer left a request without producing a result");

endmodule

`default_nettype wire

/* dv/echo_flow_table_tb.sv */
module echo_flow_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import eft_pkg::*;

	localparam int CLK_PERIOD = 10;
	localparam int RESET_CYCLES = 5;
	// A lookup miss walks the whole table, so settle for a bit longer than that.
	localparam int SETTLE_CYCLES = MAX_ENTRIES + 8;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_ITEMS = 1550;
	localparam int MAX_PRINTS = 50;
	localparam int RUN_LIMIT_NS = 5_000_000;

	typedef enum int {
		MIX_FILL,
		MIX_CHURN,
		MIX_DRAIN,
		MIX_REPLY
	} traffic_mix_t;

	typedef struct {
		req_t              kind;
		logic [ADDR_W-1:0] src;
		logic [ADDR_W-1:0] dst;
		logic [ID_W-1:0]   id;
		logic [ADDR_W-1:0] redir;
		logic [TIME_W-1:0] now;
		logic [IN_SLOT_W-1:0] slot;
		logic [ADDR_W-1:0] peer;
	} flow_req_t;

	typedef struct {
		status_t              status;
		logic [OUT_SLOT_W-1:0] slot;
		logic [ADDR_W-1:0]    fwd;
		logic [ADDR_W-1:0]    guest;
		logic [ID_W-1:0]      id;
	} flow_result_t;

	typedef struct {
		logic [ADDR_W-1:0] src;
		logic [ADDR_W-1:0] dst;
		logic [ID_W-1:0]   id;
	} flow_key_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [1:0]            req_type = '0;
	logic [ADDR_W-1:0]     source_addr = '0;
	logic [ADDR_W-1:0]     dst_addr = '0;
	logic [ID_W-1:0]       echo_id = '0;
	logic [ADDR_W-1:0]     redirect_addr = '0;
	logic [TIME_W-1:0]     now_seconds = '0;
	logic [IN_SLOT_W-1:0]  slot_index = '0;
	logic [ADDR_W-1:0]     peer_addr = '0;

	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [2:0]            status;
	logic [OUT_SLOT_W-1:0] slot_out;
	logic [ADDR_W-1:0]     forward_addr;
	logic [ADDR_W-1:0]     guest_addr;
	logic [ID_W-1:0]       id_out;

	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [TMO_W-1:0]      cfg_data = '0;

	// Shadow of the flow table, advanced once per accepted item.
	logic              tbl_live [MAX_ENTRIES] = '{default: 1'b0};
	logic [ADDR_W-1:0] tbl_src [MAX_ENTRIES] = '{default: '0};
	logic [ADDR_W-1:0] tbl_dst [MAX_ENTRIES] = '{default: '0};
	logic [ID_W-1:0]   tbl_id [MAX_ENTRIES] = '{default: '0};
	logic [ADDR_W-1:0] tbl_redir [MAX_ENTRIES] = '{default: '0};
	logic [TIME_W-1:0] tbl_last [MAX_ENTRIES] = '{default: '0};
	int                tbl_count = 0;
	logic [TMO_W-1:0]  tbl_timeout = TIMEOUT_RESET;

	flow_result_t flow_expect[$];
	flow_key_t    key_pool[$];
	logic [TIME_W-1:0] clock_s = '0;
	int items_sent = 0;
	int err_count = 0;

	// Idling controls.
	bit src_gaps_on = 1'b1;
	logic sink_stalls_on = 1'b1;
	int hold_go = 0;
	int hold_seen = 0;
	int hold_left = 0;

	echo_flow_table uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.source_addr  (source_addr),
		.dst_addr     (dst_addr),
		.echo_id      (echo_id),
		.redirect_addr(redirect_addr),
		.now_seconds  (now_seconds),
		.slot_index   (slot_index),
		.peer_addr    (peer_addr),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.slot_out     (slot_out),
		.forward_addr (forward_addr),
		.guest_addr   (guest_addr),
		.id_out       (id_out),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Hard limit on the whole run.
	initial begin
		#(RUN_LIMIT_NS);
		$display("FAIL");
		$finish;
	end

	task automatic report_error(string msg);
		if (err_count < MAX_PRINTS) begin
			$display("[%0t] mismatch: %s", $time, msg);
		end
		err_count++;
	endtask

	// Apply one request to the shadow table and return the result it must produce.
	function automatic flow_result_t flow_predict(flow_req_t r);
		flow_result_t res;
		int hit;
		int free_idx;
		int s;
		logic [TIME_W-1:0] idle;
		res.status = ST_NONE;
		res.slot = '0;
		res.fwd = '0;
		res.guest = '0;
		res.id = '0;
		hit = -1;
		free_idx = -1;
		s = int'(r.slot);
		if (r.kind == REQ_LOOKUP) begin
			// Walking downward leaves the lowest matching and lowest free slot.
			for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
				if (tbl_live[i] && tbl_src[i] == r.src && tbl_dst[i] == r.dst &&
						tbl_id[i] == r.id) begin
					hit = i;
				end
				if (!tbl_live[i]) begin
					free_idx = i;
				end
			end
			if (hit >= 0) begin
				tbl_last[hit] = r.now;
				res.status = ST_MATCH;
				res.slot = OUT_SLOT_W'(hit);
				res.fwd = (tbl_redir[hit] != '0) ? tbl_redir[hit] : tbl_dst[hit];
			end else if (tbl_count >= MAX_ENTRIES || free_idx < 0) begin
				res.status = ST_FULL;
			end else begin
				tbl_live[free_idx] = 1'b1;
				tbl_src[free_idx] = r.src;
				tbl_dst[free_idx] = r.dst;
				tbl_id[free_idx] = r.id;
				tbl_redir[free_idx] = r.redir;
				tbl_last[free_idx] = r.now;
				tbl_count++;
				res.status = ST_CREATED;
				res.slot = OUT_SLOT_W'(free_idx);
				res.fwd = (r.redir != '0) ? r.redir : r.dst;
			end
		end else if (s < MAX_ENTRIES && tbl_live[s]) begin
			case (r.kind)
				REQ_REMOVE: begin
					tbl_live[s] = 1'b0;
					tbl_count--;
					res.status = ST_REMOVED;
					res.slot = OUT_SLOT_W'(s);
				end
				REQ_AGE: begin
					// Idle time wraps modulo 2^32; equal to the timeout is still fresh.
					idle = r.now - tbl_last[s];
					if (idle > TIME_W'(tbl_timeout)) begin
						tbl_live[s] = 1'b0;
						tbl_count--;
						res.status = ST_REMOVED;
						res.slot = OUT_SLOT_W'(s);
					end
				end
				default: begin
					tbl_last[s] = r.now;
					res.status = ST_MATCH;
					res.slot = OUT_SLOT_W'(s);
					res.fwd = (tbl_redir[s] != '0) ? tbl_dst[s] : r.peer;
					res.guest = tbl_src[s];
					res.id = tbl_id[s];
				end
			endcase
		end
		return res;
	endfunction

	task automatic check_result();
		flow_result_t want;
		if (flow_expect.size() == 0) begin
			report_error("result with no item outstanding");
			return;
		end
		want = flow_expect.pop_front();
		if (status !== want.status) begin
			report_error($sformatf("status got %0d want %0d", status, want.status));
		end
		if (slot_out !== want.slot) begin
			report_error($sformatf("slot_out got %0d want %0d", slot_out, want.slot));
		end
		if (forward_addr !== want.fwd) begin
			report_error($sformatf("forward_addr got %h want %h", forward_addr, want.fwd));
		end
		if (guest_addr !== want.guest) begin
			report_error($sformatf("guest_addr got %h want %h", guest_addr, want.guest));
		end
		if (id_out !== want.id) begin
			report_error($sformatf("id_out got %h want %h", id_out, want.id));
		end
	endtask

	// Watch all three channels; the values read here are the ones the edge sampled.
	always @(posedge clk) begin : tracker
		flow_req_t taken;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				check_result();
			end
			if (in_valid && !in_stall) begin
				taken.kind = req_t'(req_type);
				taken.src = source_addr;
				taken.dst = dst_addr;
				taken.id = echo_id;
				taken.redir = redirect_addr;
				taken.now = now_seconds;
				taken.slot = slot_index;
				taken.peer = peer_addr;
				flow_expect.push_back(flow_predict(taken));
			end
			if (cfg_valid && cfg_ready) begin
				tbl_timeout = cfg_data;
			end
		end
	end

	// Result side: a requested hold-off first, otherwise random stalls.
	always @(posedge clk) begin
		if (hold_go != hold_seen) begin
			hold_seen <= hold_go;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= sink_stalls_on && ($urandom_range(99) < 16);
		end
	end

	// Offer one item and wait until it is taken; valid stays up for a following item.
	task automatic send_req(flow_req_t r);
		if (src_gaps_on) begin
			while ($urandom_range(99) < 16) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		req_type <= r.kind;
		source_addr <= r.src;
		dst_addr <= r.dst;
		echo_id <= r.id;
		redirect_addr <= r.redir;
		now_seconds <= r.now;
		slot_index <= r.slot;
		peer_addr <= r.peer;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		items_sent++;
	endtask

	// Drop valid and let every expected result come back.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (flow_expect.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_timeout(logic [TMO_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic flow_req_t lookup_req(logic [ADDR_W-1:0] src, logic [ADDR_W-1:0] dst,
			logic [ID_W-1:0] id, logic [ADDR_W-1:0] redir, logic [TIME_W-1:0] now);
		flow_req_t r;
		r.kind = REQ_LOOKUP;
		r.src = src;
		r.dst = dst;
		r.id = id;
		r.redir = redir;
		r.now = now;
		r.slot = IN_SLOT_W'($urandom());
		r.peer = $urandom();
		return r;
	endfunction

	function automatic flow_req_t slot_req(req_t kind, logic [IN_SLOT_W-1:0] slot,
			logic [TIME_W-1:0] now, logic [ADDR_W-1:0] peer);
		flow_req_t r;
		r.kind = kind;
		r.src = $urandom();
		r.dst = $urandom();
		r.id = ID_W'($urandom());
		r.redir = $urandom();
		r.now = now;
		r.slot = slot;
		r.peer = peer;
		return r;
	endfunction

	// Random request: lookups mostly revisit known flows, slot requests mostly hit live slots.
	function automatic flow_req_t random_flow_req(traffic_mix_t mix);
		flow_req_t r;
		flow_key_t k;
		int look_pct;
		int pick;
		int live_slots[$];
		case (mix)
			MIX_FILL:  look_pct = 80;
			MIX_CHURN: look_pct = 50;
			MIX_DRAIN: look_pct = 15;
			default:   look_pct = 25;
		endcase
		r = slot_req(REQ_LOOKUP, IN_SLOT_W'($urandom()), clock_s, $urandom());
		if ($urandom_range(1)) begin
			r.redir = '0;
		end
		if ($urandom_range(99) < 3) begin
			r.now = $urandom();
		end
		clock_s += TIME_W'($urandom_range(2));
		if ($urandom_range(99) < look_pct) begin
			pick = $urandom_range(99);
			if (pick < 55 && key_pool.size() > 0) begin
				k = key_pool[$urandom_range(key_pool.size() - 1)];
				r.src = k.src;
				r.dst = k.dst;
				r.id = k.id;
				// A near miss: one key bit differs from a known flow.
				if (pick < 8) begin
					case ($urandom_range(2))
						0: r.src ^= ADDR_W'(1) << $urandom_range(ADDR_W - 1);
						1: r.dst ^= ADDR_W'(1) << $urandom_range(ADDR_W - 1);
						default: r.id ^= ID_W'(1) << $urandom_range(ID_W - 1);
					endcase
				end
			end
			if (pick < 8 || pick >= 55) begin
				k.src = r.src;
				k.dst = r.dst;
				k.id = r.id;
				key_pool.push_back(k);
				if (key_pool.size() > 96) begin
					void'(key_pool.pop_front());
				end
			end
		end else begin
			case ($urandom_range(2))
				0: r.kind = REQ_REMOVE;
				1: r.kind = REQ_AGE;
				default: r.kind = REQ_REPLY;
			endcase
			if (mix == MIX_REPLY && $urandom_range(1)) begin
				r.kind = REQ_REPLY;
			end
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				if (tbl_live[i]) begin
					live_slots.push_back(i);
				end
			end
			if (live_slots.size() > 0 && $urandom_range(99) < 85) begin
				r.slot = IN_SLOT_W'(live_slots[$urandom_range(live_slots.size() - 1)]);
			end
			if (r.kind == REQ_AGE) begin
				if ($urandom_range(9) == 0) begin
					r.now = $urandom();
				end else begin
					r.now = clock_s + TIME_W'($urandom_range(32'(tbl_timeout) * 2 + 2));
				end
			end
		end
		return r;
	endfunction

	// Every request kind, field extremes, redirect both ways, aging edges and wrap.
	task automatic test_basic_ops();
		send_req(lookup_req('1, '0, '1, '0, '0));
		send_req(lookup_req('0, '1, '0, '1, '1));
		send_req(lookup_req('1, '0, '1, 32'h1234_5678, 32'd5));
		send_req(lookup_req('0, '1, '0, '0, '1));
		send_req(lookup_req('1, '0, 16'hFFFE, 32'hA5A5_A5A5, 32'd7));
		send_req(slot_req(REQ_REPLY, 5'd0, 32'd6, 32'h5A5A_5A5A));
		send_req(slot_req(REQ_REPLY, 5'd1, '1, 32'h1111_1111));
		send_req(slot_req(REQ_REPLY, 5'd31, 32'd8, '1));
		// Idle exactly at the timeout stays, one more second ages out.
		send_req(slot_req(REQ_AGE, 5'd0, 32'd16, '0));
		send_req(slot_req(REQ_AGE, 5'd0, 32'd17, '0));
		// The same across the wrap of the seconds counter.
		send_req(slot_req(REQ_AGE, 5'd1, 32'd9, '0));
		send_req(slot_req(REQ_AGE, 5'd1, 32'd10, '0));
		send_req(slot_req(REQ_REMOVE, 5'd0, 32'd11, '0));
		send_req(slot_req(REQ_AGE, 5'd30, 32'd12, '0));
		send_req(lookup_req(32'h0A00_0002, 32'h0808_0808, 16'h1234, '0, 32'd20));
		send_req(slot_req(REQ_REMOVE, 5'd2, 32'd21, '0));
		send_req(slot_req(REQ_REMOVE, 5'd0, 32'd22, '0));
		send_req(slot_req(REQ_REPLY, 5'd0, 32'd23, '1));
		wait_idle();
	endtask

	// Zero and maximum timeout, then back to the reset value.
	task automatic test_timeout_extremes();
		write_timeout('0);
		send_req(lookup_req(32'hC0A8_0001, 32'h0101_0101, 16'h0001, '0, 32'd100));
		send_req(slot_req(REQ_AGE, 5'd0, 32'd100, '0));
		send_req(slot_req(REQ_AGE, 5'd0, 32'd101, '0));
		wait_idle();
		write_timeout('1);
		send_req(lookup_req(32'hC0A8_0002, 32'h0101_0102, 16'h0002, 32'h0202_0202, '0));
		send_req(slot_req(REQ_AGE, 5'd0, 32'h0000_FFFF, '0));
		send_req(slot_req(REQ_AGE, 5'd0, 32'h0001_0000, '0));
		wait_idle();
		write_timeout(TIMEOUT_RESET);
	endtask

	// Fill every slot, miss on a full table, reuse a freed slot, then empty it.
	task automatic test_table_full();
		flow_key_t keys[MAX_ENTRIES];
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			keys[i].src = $urandom();
			keys[i].dst = $urandom();
			keys[i].id = ID_W'(i);
			send_req(lookup_req(keys[i].src, keys[i].dst, keys[i].id,
				(i % 2 != 0) ? ADDR_W'($urandom()) : '0, clock_s));
		end
		send_req(lookup_req($urandom(), $urandom(), '1, '0, clock_s));
		send_req(lookup_req(keys[5].src, keys[5].dst, keys[5].id, '0, clock_s));
		send_req(slot_req(REQ_REPLY, 5'd31, clock_s, $urandom()));
		send_req(slot_req(REQ_REMOVE, 5'd13, clock_s, '0));
		send_req(lookup_req($urandom(), $urandom(), 16'hBEEF, $urandom(), clock_s));
		send_req(lookup_req($urandom(), $urandom(), 16'hCAFE, '0, clock_s));
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			send_req(slot_req(REQ_REMOVE, IN_SLOT_W'(i), clock_s, '0));
		end
		wait_idle();
	endtask

	// Hold the result side off while items keep coming, so the input backs up.
	task automatic test_receiver_holdoff();
		hold_go <= hold_go + 1;
		for (int n = 0; n < 60; n++) begin
			send_req(random_flow_req(MIX_CHURN));
		end
		wait_idle();
	endtask

	// Random rounds, each with its own traffic mix and timeout setting.
	task automatic test_random_traffic();
		int round;
		int stop_round;
		int stop_all;
		round = 0;
		stop_all = items_sent + RANDOM_ITEMS;
		while (items_sent < stop_all) begin
			wait_idle();
			case (round % 5)
				0: write_timeout('0);
				1: write_timeout('1);
				default: write_timeout(TMO_W'($urandom_range(1, 24)));
			endcase
			if (round == 4) begin
				clock_s = 32'hFFFF_FF00;
			end
			// One round runs with no idling on either side.
			src_gaps_on = (round != 2);
			sink_stalls_on <= (round != 2);
			stop_round = items_sent + $urandom_range(100, 160);
			while (items_sent < stop_round) begin
				send_req(random_flow_req(traffic_mix_t'(round % 4)));
			end
			round++;
		end
		src_gaps_on = 1'b1;
		sink_stalls_on <= 1'b1;
		wait_idle();
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_ops();
		test_timeout_extremes();
		test_table_full();
		test_receiver_holdoff();
		test_random_traffic();
		wait_idle();
		if (err_count == 0 && flow_expect.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
